// File: rtl/ile_pkg.sv
// Shared types and codes for the indexed list engine.
`timescale 1ns / 1ps

package ile_pkg;

   // Operation codes carried by a request
   typedef enum logic [2:0] {
      FUNC_APPEND = 3'd0,
      FUNC_UPDATE = 3'd1,
      FUNC_REMOVE = 3'd2,
      FUNC_INSERT = 3'd3,
      FUNC_GET    = 3'd4,
      FUNC_POP    = 3'd5,
      FUNC_CLEAR  = 3'd6
   } func_type;

   // Status codes returned with each result
   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_EMPTY = 2'd3
   } status_type;

   // Per-cycle command broadcast to every entry cell
   typedef struct packed {
      logic shift_up;    // cells above the position take their lower neighbor
      logic shift_down;  // cells at or above the position take their upper neighbor
      logic write_en;    // the cell at the position takes the request value
   } ctrl_type;

endpackage

// File: rtl/ile_cell.sv
// One entry cell of the list chain: holds a word and moves it with its neighbors.
`timescale 1ns / 1ps

module ile_cell #(
   parameter int ELEMENT_WIDTH = 32,
   parameter int POS_WIDTH     = 4,
   parameter int CELL_INDEX    = 0
) (
   input  logic                     clock,
   input  ile_pkg::ctrl_type        ctrl,
   input  logic [POS_WIDTH-1:0]     pos,
   input  logic [ELEMENT_WIDTH-1:0] value,
   input  logic [ELEMENT_WIDTH-1:0] lower_q,
   input  logic [ELEMENT_WIDTH-1:0] upper_q,
   output logic [ELEMENT_WIDTH-1:0] entry_q
);
   import ile_pkg::*;

   localparam logic [POS_WIDTH-1:0] MyPos = POS_WIDTH'(CELL_INDEX);

   logic [ELEMENT_WIDTH-1:0] entry_ff;
   logic [ELEMENT_WIDTH-1:0] entry_in;

   // Pick the next word: own value, a neighbor, or the request value
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write_en && (MyPos == pos)) begin
         entry_in = value;
      end else if (ctrl.shift_up && (MyPos > pos)) begin
         entry_in = lower_q;
      end else if (ctrl.shift_down && (MyPos >= pos)) begin
         entry_in = upper_q;
      end
   end

   // Hold the entry word
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule

// File: rtl/indexed_list_engine.sv
// Top level of the indexed list engine: control, fill count and the cell chain.
`timescale 1ns / 1ps

// Dense ordered list of up to DEPTH words with append, update, remove, insert,
// get, pop and clear. A request is taken whenever start is high; busy is always
// low, so a new request may be issued every cycle. Each request produces exactly
// one result, shown with rsp_valid for one cycle, in the cycle after the request
// was taken. The receiver cannot stall; capture the result in the cycle it is
// strobed. All entries live in a chain of cells that shift together in the same
// cycle, so inserts and removes are handled like any other request. The data
// port carries the low 32 bits of an element.

module indexed_list_engine #(
   parameter int DEPTH         = 16,
   parameter int ELEMENT_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_index,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_data,
   output logic [4:0]  rsp_count
);
   import ile_pkg::*;

   localparam int FillWidth = $clog2(DEPTH + 1);
   localparam int PosWidth  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CmpWidth  = (FillWidth > 4) ? FillWidth : 4;
   localparam logic [FillWidth-1:0] FillMax = FillWidth'(DEPTH);

   logic [FillWidth-1:0] fill_ff;
   logic [FillWidth-1:0] fill_in;

   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [1:0]  rsp_status_in;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;
   logic [4:0]  rsp_count_ff;

   logic [CmpWidth-1:0]      idx_c;
   logic [CmpWidth-1:0]      fill_c;
   logic                     full;
   logic                     idx_in_range;
   logic [PosWidth-1:0]      idx_pos;
   logic [PosWidth-1:0]      last_pos;
   logic [PosWidth-1:0]      rd_pos;
   logic [PosWidth-1:0]      cell_pos;
   logic [ELEMENT_WIDTH-1:0] value_e;
   logic [ELEMENT_WIDTH-1:0] rd_word;
   logic                     rd_take;
   ctrl_type                 ctrl;
   func_type                 func;

   logic [ELEMENT_WIDTH-1:0] cell_q [DEPTH];

   assign busy    = 1'b0;
   assign func    = func_type'(req_func);
   assign value_e = ELEMENT_WIDTH'(req_value);

   // Compare index and fill at a common width
   assign idx_c        = CmpWidth'(req_index);
   assign fill_c       = CmpWidth'(fill_ff);
   assign full         = (fill_ff == FillMax);
   assign idx_in_range = (idx_c < fill_c);
   assign idx_pos      = idx_c[PosWidth-1:0];
   assign last_pos     = PosWidth'(fill_ff - FillWidth'(1));

   // Decode the request into a cell command, status and new fill
   always_comb begin
      ctrl          = '0;
      cell_pos      = idx_pos;
      rd_pos        = idx_pos;
      rd_take       = 1'b0;
      fill_in       = fill_ff;
      rsp_status_in = STATUS_OK;
      unique case (func)
         FUNC_APPEND: begin
            cell_pos = PosWidth'(fill_ff);
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else begin
               ctrl.write_en = 1'b1;
               fill_in       = fill_ff + FillWidth'(1);
            end
         end
         FUNC_UPDATE: begin
            if (!idx_in_range) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               ctrl.write_en = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (!idx_in_range) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               ctrl.shift_down = 1'b1;
               rd_take         = 1'b1;
               fill_in         = fill_ff - FillWidth'(1);
            end
         end
         FUNC_INSERT: begin
            if (full) begin
               rsp_status_in = STATUS_FULL;
            end else if (idx_c > fill_c) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               ctrl.shift_up = 1'b1;
               ctrl.write_en = 1'b1;
               fill_in       = fill_ff + FillWidth'(1);
            end
         end
         FUNC_GET: begin
            if (!idx_in_range) begin
               rsp_status_in = STATUS_RANGE;
            end else begin
               rd_take = 1'b1;
            end
         end
         FUNC_POP: begin
            rd_pos = last_pos;
            if (fill_ff == '0) begin
               rsp_status_in = STATUS_EMPTY;
            end else begin
               rd_take = 1'b1;
               fill_in = fill_ff - FillWidth'(1);
            end
         end
         FUNC_CLEAR: begin
            fill_in = '0;
         end
         default: begin
         end
      endcase
      if (!start) begin
         ctrl    = '0;
         fill_in = fill_ff;
      end
   end

   // Select the word that is read or removed
   assign rd_word     = cell_q[rd_pos];
   assign rsp_data_in = rd_take ? 32'(rd_word) : 32'd0;

   // Build the chain of entry cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [ELEMENT_WIDTH-1:0] lower_w;
      logic [ELEMENT_WIDTH-1:0] upper_w;
      if (g == 0) begin : g_first
         assign lower_w = value_e;
      end else begin : g_mid_lo
         assign lower_w = cell_q[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign upper_w = '0;
      end else begin : g_mid_hi
         assign upper_w = cell_q[g+1];
      end
      ile_cell #(
         .ELEMENT_WIDTH (ELEMENT_WIDTH),
         .POS_WIDTH     (PosWidth),
         .CELL_INDEX    (g)
      ) u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .pos     (cell_pos),
         .value   (value_e),
         .lower_q (lower_w),
         .upper_q (upper_w),
         .entry_q (cell_q[g])
      );
   end

   // Advance the fill count and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= start;
      end
   end

   // Capture the result payload
   always_ff @(posedge clock) begin
      if (start) begin
         rsp_status_ff <= rsp_status_in;
         rsp_data_ff   <= rsp_data_in;
         rsp_count_ff  <= 5'(fill_in);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

// File: dv/indexed_list_engine_checker.sv
// Result checker for the indexed list engine: list prediction and per-field compare.
`timescale 1ns / 1ps

module indexed_list_engine_checker #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_func,
   input  logic [3:0]  req_index,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [31:0] rsp_data,
   input  logic [4:0]  rsp_count,
   output int          fail_count,
   output int          pending
);
   import ile_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [31:0] data;
      logic [4:0]  count;
   } list_result_type;

   // Shadow copy of the list contents and its length
   logic [31:0]     list_words [DEPTH];
   logic [4:0]      list_fill = '0;
   list_result_type expected_results [$];
   int              mismatches = 0;

   // Apply one request to the shadow list and return the result it should give
   function automatic list_result_type apply_list_op(input logic [2:0]  op,
                                                     input logic [3:0]  pos,
                                                     input logic [31:0] word);
      list_result_type res;
      int              i;
      res.status = STATUS_OK;
      res.data   = '0;
      case (op)
         FUNC_APPEND: begin
            if (list_fill >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               list_words[list_fill] = word;
               list_fill = list_fill + 1'b1;
            end
         end
         FUNC_UPDATE: begin
            if (pos >= list_fill) res.status = STATUS_RANGE;
            else list_words[pos] = word;
         end
         FUNC_REMOVE: begin
            if (pos >= list_fill) begin
               res.status = STATUS_RANGE;
            end else begin
               res.data = list_words[pos];
               // close the gap left by the removed entry
               for (i = pos; i + 1 < list_fill; i++) list_words[i] = list_words[i + 1];
               list_fill = list_fill - 1'b1;
            end
         end
         FUNC_INSERT: begin
            if (list_fill >= DEPTH) begin
               res.status = STATUS_FULL;
            end else if (pos > list_fill) begin
               res.status = STATUS_RANGE;
            end else begin
               // open a slot at the position, moving later entries up
               for (i = list_fill; i > pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos] = word;
               list_fill = list_fill + 1'b1;
            end
         end
         FUNC_GET: begin
            if (pos >= list_fill) res.status = STATUS_RANGE;
            else res.data = list_words[pos];
         end
         FUNC_POP: begin
            if (list_fill == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               list_fill = list_fill - 1'b1;
               res.data  = list_words[list_fill];
            end
         end
         FUNC_CLEAR: list_fill = '0;
         default: ;
      endcase
      res.count = list_fill;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         list_fill = '0;
         expected_results.delete();
      end else begin
         // compare the strobed result with the oldest expectation first
         if (rsp_valid === 1'b1) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual %0d %h %0d",
                        $time, rsp_status, rsp_data, rsp_count);
               mismatches++;
            end else begin
               list_result_type want;
               want = expected_results.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_data !== want.data) begin
                  $display("%0t: data mismatch: expected %h, actual %h",
                           $time, want.data, rsp_data);
                  mismatches++;
               end
               if (rsp_count !== want.count) begin
                  $display("%0t: count mismatch: expected %0d, actual %0d",
                           $time, want.count, rsp_count);
                  mismatches++;
               end
            end
         end
         // predict the request taken at this edge
         if (start === 1'b1 && busy === 1'b0)
            expected_results.push_back(apply_list_op(req_func, req_index, req_value));
      end
      fail_count <= mismatches;
      pending    <= expected_results.size();
   end

endmodule

// File: dv/indexed_list_engine_tb.sv
// Testbench top for the indexed list engine: request stimulus and final verdict.
`timescale 1ns / 1ps

module indexed_list_engine_tb;
   import ile_pkg::*;

   localparam int         DEPTH        = 16;
   localparam int         RANDOM_ITEMS = 800;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         QUIET_FIRST  = 300;
   localparam int         QUIET_LAST   = 450;
   localparam logic [2:0] FUNC_NOP     = 3'd7;

   typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} mode_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_func;
   logic [3:0]  req_index;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_data;
   logic [4:0]  rsp_count;

   int fail_count;
   int pending;
   int cycle_count = 0;
   int sent        = 0;
   int list_len    = 0;
   bit allow_idle  = 1'b1;

   indexed_list_engine #(.DEPTH(DEPTH), .ELEMENT_WIDTH(32)) dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_count(rsp_count)
   );

   indexed_list_engine_checker #(.DEPTH(DEPTH)) list_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_index(req_index), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data(rsp_data),
      .rsp_count(rsp_count), .fail_count(fail_count), .pending(pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Track the list length so indexes mostly land inside the list
   function automatic int next_len(input logic [2:0] func, input logic [3:0] index,
                                   input int len);
      case (func)
         FUNC_APPEND: return (len < DEPTH) ? len + 1 : len;
         FUNC_INSERT: return (len < DEPTH && index <= len) ? len + 1 : len;
         FUNC_REMOVE: return (index < len) ? len - 1 : len;
         FUNC_POP:    return (len > 0) ? len - 1 : len;
         FUNC_CLEAR:  return 0;
         default:     return len;
      endcase
   endfunction

   function automatic logic [2:0] pick_func(input mode_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         MODE_GROW: begin
            if (roll < 45) return FUNC_APPEND;
            if (roll < 80) return FUNC_INSERT;
            if (roll < 90) return FUNC_UPDATE;
            return FUNC_GET;
         end
         MODE_SHRINK: begin
            if (roll < 40) return FUNC_REMOVE;
            if (roll < 75) return FUNC_POP;
            if (roll < 90) return FUNC_GET;
            return FUNC_UPDATE;
         end
         MODE_MIXED: begin
            if (roll < 2)  return FUNC_CLEAR;
            if (roll < 18) return FUNC_APPEND;
            if (roll < 34) return FUNC_INSERT;
            if (roll < 50) return FUNC_REMOVE;
            if (roll < 64) return FUNC_POP;
            if (roll < 82) return FUNC_GET;
            return FUNC_UPDATE;
         end
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   function automatic logic [3:0] pick_index(input logic [2:0] func, input int len);
      int top_pos;
      if (len == 0 || $urandom_range(0, 99) < 15) return 4'($urandom_range(0, 15));
      top_pos = (func == FUNC_INSERT) ? len : len - 1;
      if (top_pos > 15) top_pos = 15;
      return 4'($urandom_range(0, top_pos));
   endfunction

   function automatic logic [31:0] pick_value();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 32'h0000_0000;
      if (roll == 1) return 32'hFFFF_FFFF;
      return $urandom;
   endfunction

   // Issue one request and hold it until the block takes it
   task automatic send_request(input logic [2:0] func, input logic [3:0] index,
                               input logic [31:0] value);
      while (allow_idle && $urandom_range(0, 99) < 25) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_index <= index;
      req_value <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      list_len = next_len(func, index, list_len);
      sent++;
   endtask

   initial begin
      mode_type    mode;
      int          phase_len;
      int          random_sent;
      logic [2:0]  func;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_func  <= FUNC_APPEND;
      req_index <= '0;
      req_value <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty-list failures: pop gives empty, index checks give range
      send_request(FUNC_POP,    4'd0,  32'h0);
      send_request(FUNC_GET,    4'd0,  32'h0);
      send_request(FUNC_REMOVE, 4'd0,  32'h0);
      send_request(FUNC_UPDATE, 4'd0,  32'h1);
      send_request(FUNC_INSERT, 4'd1,  32'h2);
      // build a short list through insert at zero, append and insert at the end
      send_request(FUNC_INSERT, 4'd0,  32'hFFFF_FFFF);
      send_request(FUNC_APPEND, 4'd0,  32'h0000_0000);
      send_request(FUNC_INSERT, 4'd2,  32'h1234_5678);
      send_request(FUNC_INSERT, 4'd15, 32'hDEAD_BEEF);
      send_request(FUNC_INSERT, 4'd1,  32'h8000_0001);
      send_request(FUNC_UPDATE, 4'd3,  32'hA5A5_A5A5);
      send_request(FUNC_GET,    4'd3,  32'h0);
      send_request(FUNC_GET,    4'd15, 32'h0);
      send_request(FUNC_REMOVE, 4'd0,  32'h0);
      send_request(FUNC_REMOVE, 4'd2,  32'h0);
      send_request(FUNC_NOP,    4'd5,  32'h5A5A_5A5A);
      send_request(FUNC_POP,    4'd0,  32'h0);
      send_request(FUNC_CLEAR,  4'd9,  32'h0);
      send_request(FUNC_GET,    4'd0,  32'h0);
      send_request(FUNC_POP,    4'd0,  32'h0);

      // random phases that fill, drain and churn the list
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1, 2: mode = MODE_GROW;
            3, 4, 5: mode = MODE_SHRINK;
            6, 7, 8: mode = MODE_MIXED;
            default: mode = MODE_NOISE;
         endcase
         phase_len = $urandom_range(10, 40);
         for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
            allow_idle = !(random_sent >= QUIET_FIRST && random_sent < QUIET_LAST);
            func = pick_func(mode);
            send_request(func, pick_index(func, list_len), pick_value());
            random_sent++;
         end
      end
      start <= 1'b0;

      // drain outstanding results, then allow for the output latency
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
